>>> rtl/sprite_xor_framebuffer_assert.svh
// Assertion macros shared by the sprite framebuffer RTL.
`ifndef SPRITE_XOR_FRAMEBUFFER_ASSERT_SVH
`define SPRITE_XOR_FRAMEBUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SXF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite framebuffer assertion failed");

// Next-cycle implication, checked outside reset.
`define SXF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite framebuffer assertion failed");

`endif

>>> rtl/sxf_pkg.sv
// Shared constants, types and functions for the sprite framebuffer.
`default_nettype none

package sxf_pkg;

  // Screen geometry; one stored word per screen row
  localparam int SCREEN_W   = 64;
  localparam int SCREEN_H   = 32;
  localparam int SPRITE_W   = 8;
  localparam int COL_W      = $clog2(SCREEN_W);
  localparam int ROW_W      = $clog2(SCREEN_H);
  localparam int ROFF_W     = 4;
  localparam int ROW_SUM_W  = $clog2(SCREEN_H + (1 << ROFF_W) - 1);
  localparam int COORD_W    = 8;

  // Operation codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [SCREEN_W-1:0] row_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // take the item and read its row
    logic commit;    // write back and load the result register
  } cmd_t;

  // Spread a sprite byte over a screen row, bit 7 landing on column col
  function automatic row_t place_byte(input logic [SPRITE_W-1:0] bits,
                                      input logic [COL_W-1:0] col);
    row_t           mask;
    logic [COL_W:0] c;
    mask = '0;
    for (int i = 0; i < SPRITE_W; i++) begin
      c = {1'b0, col} + (COL_W + 1)'(i);
      if ((c < (COL_W + 1)'(SCREEN_W)) && bits[3'(SPRITE_W - 1 - i)]) begin
        mask[c[COL_W-1:0]] = 1'b1;
      end
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sxf_in_if.sv
// Input item channel: draw or read request.
`default_nettype none

interface sxf_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [sxf_pkg::COORD_W-1:0]       x_coord;
  logic [sxf_pkg::COORD_W-1:0]       y_coord;
  logic [sxf_pkg::ROFF_W-1:0]        row_offset;
  logic [sxf_pkg::ROFF_W-1:0]        row_count;
  logic [sxf_pkg::SPRITE_W-1:0]      sprite_bits;

  modport source (output valid, op, x_coord, y_coord, row_offset, row_count, sprite_bits,
                  input ready);
  modport sink (input valid, op, x_coord, y_coord, row_offset, row_count, sprite_bits,
                output ready);
endinterface

`default_nettype wire

>>> rtl/sxf_out_if.sv
// Result item channel: collision flag, framebuffer row and sprite-done flag.
`default_nettype none

interface sxf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       collision;
  logic [sxf_pkg::SCREEN_W-1:0] row_pixels;
  logic                       sprite_done;

  modport source (output valid, collision, row_pixels, sprite_done, input ready);
  modport sink (input valid, collision, row_pixels, sprite_done, output ready);
endinterface

`default_nettype wire

>>> rtl/sxf_ctrl.sv
// Controller: accepts items, sequences read and write-back, owns result valid.
`default_nettype none
`include "sprite_xor_framebuffer_assert.svh"

module sxf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sxf_pkg::cmd_t      cmd
);
  import sxf_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  // Handshake and command decode
  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign slot_free   = !out_valid_r || out_ready;
  assign cmd.capture = accept;
  assign cmd.commit  = (state_r == S_EXEC) && slot_free;
  assign out_valid   = out_valid_r;

  // Next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SXF_ASSERT_NEXT(a_accept_then_busy, accept, !in_ready)
  `SXF_ASSERT_NEXT(a_no_overwrite, (state_r == S_EXEC) && out_valid_r && !out_ready, state_r == S_EXEC)
  `SXF_ASSERT_NEXT(a_commit_gives_result, cmd.commit, out_valid_r)

endmodule

`default_nettype wire

>>> rtl/sxf_datapath.sv
// Datapath: frame store, sprite placement, XOR, collision and result register.
`default_nettype none
`include "sprite_xor_framebuffer_assert.svh"

module sxf_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire sxf_pkg::cmd_t                  cmd,
  input  wire logic                           in_op,
  input  wire logic [sxf_pkg::COORD_W-1:0]    in_x_coord,
  input  wire logic [sxf_pkg::COORD_W-1:0]    in_y_coord,
  input  wire logic [sxf_pkg::ROFF_W-1:0]     in_row_offset,
  input  wire logic [sxf_pkg::ROFF_W-1:0]     in_row_count,
  input  wire logic [sxf_pkg::SPRITE_W-1:0]   in_sprite_bits,
  output logic                                out_collision,
  output sxf_pkg::row_t                       out_row_pixels,
  output logic                                out_sprite_done
);
  import sxf_pkg::*;

  // Frame store and per-row valid bits (an unwritten row reads as blank)
  row_t                 mem [SCREEN_H];
  logic [SCREEN_H-1:0]  valid_r;
  row_t                 rdata_r;
  logic                 rd_valid_r;

  // Captured item
  logic                 op_r;
  logic [COL_W-1:0]     col_r;
  logic [ROW_SUM_W-1:0] row_r;
  logic [ROFF_W-1:0]    roff_r;
  logic [ROFF_W-1:0]    rcnt_r;
  logic [SPRITE_W-1:0]  bits_r;

  logic                 coll_r, coll_nxt;
  row_t                 pix_r;
  logic                 done_r;

  logic [ROW_SUM_W-1:0] row_in;
  row_t                 old_row;
  row_t                 mask;
  row_t                 new_row;
  logic                 in_screen;
  logic                 draw_now;
  logic                 hit;
  logic                 done_now;
  row_t                 pix_nxt;

  // Target row: low bits of y (screen height is a power of two), plus offset for a draw
  always_comb begin
    if (in_op == OP_READ) begin
      row_in = ROW_SUM_W'(in_y_coord[ROW_W-1:0]);
    end else begin
      row_in = ROW_SUM_W'(in_y_coord[ROW_W-1:0]) + ROW_SUM_W'(in_row_offset);
    end
  end

  // Capture the item's fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      col_r  <= in_x_coord[COL_W-1:0];
      row_r  <= row_in;
      roff_r <= in_row_offset;
      rcnt_r <= in_row_count;
      bits_r <= in_sprite_bits;
    end
  end

  // Row update logic
  assign old_row   = rd_valid_r ? rdata_r : '0;
  assign in_screen = (row_r < ROW_SUM_W'(SCREEN_H));
  assign draw_now  = (op_r == OP_DRAW) && in_screen && (roff_r < rcnt_r);
  assign mask      = draw_now ? place_byte(bits_r, col_r) : '0;
  assign new_row   = old_row ^ mask;
  assign hit       = |(old_row & mask);
  assign done_now  = (op_r == OP_DRAW) &&
                     (({1'b0, roff_r} + (ROFF_W + 1)'(1)) >= {1'b0, rcnt_r});

  always_comb begin
    coll_nxt = coll_r;
    pix_nxt  = '0;
    if (op_r == OP_READ) begin
      pix_nxt = old_row;
    end else begin
      if (roff_r == '0) begin
        coll_nxt = 1'b0;
      end
      if (hit) begin
        coll_nxt = 1'b1;
      end
      if (in_screen) begin
        pix_nxt = new_row;
      end
    end
  end

  // Frame store: read on capture, write back on commit
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdata_r <= mem[row_in[ROW_W-1:0]];
    end
    if (cmd.commit && draw_now) begin
      mem[row_r[ROW_W-1:0]] <= new_row;
    end
  end

  // Valid bits and collision flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      coll_r     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rd_valid_r <= valid_r[row_in[ROW_W-1:0]];
      end
      if (cmd.commit) begin
        coll_r <= coll_nxt;
        if (draw_now) begin
          valid_r[row_r[ROW_W-1:0]] <= 1'b1;
        end
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pix_r  <= pix_nxt;
      done_r <= done_now;
    end
  end

  assign out_collision   = coll_r;
  assign out_row_pixels  = pix_r;
  assign out_sprite_done = done_r;

  `SXF_ASSERT_NEXT(a_read_keeps_collision, cmd.commit && (op_r == OP_READ), coll_r == $past(coll_r))
  `SXF_ASSERT_NEXT(a_clipped_row_blank, cmd.commit && (op_r == OP_DRAW) && !in_screen, pix_r == '0)
  `SXF_ASSERT_NEXT(a_sprite_start_clears, cmd.commit && (op_r == OP_DRAW) && (roff_r == '0) && !hit, !coll_r)

endmodule

`default_nettype wire

>>> rtl/sprite_xor_framebuffer.sv
// Top level: 64x32 monochrome framebuffer with XOR sprite-row drawing.
//
// Usage:
//   in_chan  (valid/ready) carries one item: op 0 draws one 8-pixel sprite row
//            at (x mod 64, (y mod 32) + row_offset), op 1 reads row (y mod 32).
//   out_chan (valid/ready) returns exactly one result per item: the collision
//            flag, the affected or read 64-bit row (bit 0 = column 0) and the
//            sprite-done flag.
//   An item first has its row read from the frame store, then is XORed, written
//   back and loaded into the result register. A new item is taken only once the
//   previous one has been written back. The result is valid from the edge that
//   loads the result register.
//   The result register parts the two sides: a new item is taken while a
//   result waits. If the receiver stalls, the next item waits in the write-back
//   step until the result register frees, and further input is held off.
//   Reset (rst_n low, synchronous) blanks the whole screen at once through
//   per-row valid bits and clears the collision flag; no clearing pass.
`default_nettype none

module sprite_xor_framebuffer (
  input  wire logic clk,
  input  wire logic rst_n,
  sxf_in_if.sink    in_chan,
  sxf_out_if.source out_chan
);
  import sxf_pkg::*;

  cmd_t cmd;

  // Controller
  sxf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // Datapath
  sxf_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_op           (in_chan.op),
    .in_x_coord      (in_chan.x_coord),
    .in_y_coord      (in_chan.y_coord),
    .in_row_offset   (in_chan.row_offset),
    .in_row_count    (in_chan.row_count),
    .in_sprite_bits  (in_chan.sprite_bits),
    .out_collision   (out_chan.collision),
    .out_row_pixels  (out_chan.row_pixels),
    .out_sprite_done (out_chan.sprite_done)
  );

endmodule

`default_nettype wire
